// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the walker top file
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ftw_pkg.sv =====
// types, constants and codes for the four-level table walker
// no dependencies; used by the walker top, front and back files
package ftw_pkg;

  localparam int unsigned TABLE_WORDS_DEF = 1048576;
  localparam int unsigned TBL_IDX_W       = 20;
  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned PAGE_W          = 12;
  localparam int unsigned SLICE_W         = 9;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // table window 0xaf800000..0xb0000000 is 8 MiB aligned: tag of bits 47..23
  localparam logic [24:0] TBL_WIN_TAG = 25'h000015f;
  // memory window 0xb0000000..0xc0000000: tag of bits 47..28
  localparam logic [19:0] MEM_WIN_TAG = 20'h0000b;

  localparam int unsigned DESC_VALID_BIT = 0;
  localparam logic [1:0]  LAST_LEVEL     = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNMAPPED    = 2'd1;
  localparam logic [1:0] ST_TABLE_RANGE = 2'd2;
  localparam logic [1:0] ST_OUT_RANGE   = 2'd3;

  typedef struct packed {
    logic                 command;
    logic [TBL_IDX_W-1:0] table_index;
    logic [WORD_W-1:0]    table_word;
    logic [ADDR_W-1:0]    input_address;
  } ftw_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] output_address;
    logic [1:0]        status;
  } ftw_out_t;

  typedef struct packed {
    logic                 command;
    logic                 wr_ok;
    logic [TBL_IDX_W-1:0] table_index;
    logic [WORD_W-1:0]    table_word;
    logic [ADDR_W-1:0]    input_address;
  } ftw_job_t;

  typedef struct packed {
    logic     valid;
    ftw_job_t job;
  } ftw_q_t;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [TBL_IDX_W-1:0] addr;
    logic [WORD_W-1:0]    wdata;
  } ftw_mem_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_CHECK
  } bk_state_t;

endpackage

// ===== rtl/four_level_table_walker_range_checked.sv =====
// a write item passes the queue and the result register; a translate item passes
//   the queue, is popped, then takes a lookup and a check per level
// throughput: one write per cycle while out_stall is low; the next item waits for a
//   walk of up to four dependent reads of the single ram with registered read data
// reset clears control state and the root base; the descriptor store is not cleared
`include "assert_macros.svh"

module four_level_table_walker_range_checked #(
  parameter int unsigned TABLE_WORDS = ftw_pkg::TABLE_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ftw_pkg::ftw_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ftw_pkg::ftw_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ftw_pkg::ADDR_W-1:0] cfg_data
);
  import ftw_pkg::*;

  localparam int unsigned        AW       = $clog2(TABLE_WORDS);
  localparam logic [TBL_IDX_W:0] WordsLim = (TBL_IDX_W + 1)'(TABLE_WORDS);

  logic [ADDR_W-1:0] root_base_r;
  ftw_q_t            fq;
  logic              bk_pop;
  ftw_mem_req_t      mreq;
  logic [WORD_W-1:0] mem_rdata;
  logic              mem_idx_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_base_r <= cfg_data;
    end
  end

  ftw_front #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_out   (fq),
    .pop     (bk_pop)
  );

  ftw_back #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_in     (fq),
    .pop      (bk_pop),
    .root_base(root_base_r),
    .mem_req  (mreq),
    .mem_rdata(mem_rdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  ftw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (mreq.we),
    .waddr(mreq.addr[AW-1:0]),
    .wdata(mreq.wdata),
    .re   (mreq.re),
    .raddr(mreq.addr[AW-1:0]),
    .rdata(mem_rdata)
  );

  assign mem_idx_ok = ({1'b0, mreq.addr} < WordsLim);

  `ASSERT_NEVER(a_pop_empty, bk_pop && !fq.valid, "walker popped an empty queue")
  `ASSERT_NEVER(a_mem_excl, mreq.we && mreq.re, "store written and read in one cycle")
  `ASSERT_NEVER(a_mem_range, (mreq.we || mreq.re) && !mem_idx_ok, "store index beyond depth")
  `ASSERT_CLK(a_full_hold, in_stall && !bk_pop |=> in_stall, "queue space appeared without a pop")

endmodule

// ===== rtl/ftw_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ftw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ftw_front.sv =====
// front end: accepts items, classifies them and queues them for the walker
// depends on ftw_pkg
module ftw_front #(
  parameter int unsigned TABLE_WORDS = ftw_pkg::TABLE_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ftw_pkg::ftw_in_t in_data,
  output ftw_pkg::ftw_q_t  q_out,
  input  logic             pop
);
  import ftw_pkg::*;

  localparam logic [TBL_IDX_W:0] WordsLim = (TBL_IDX_W + 1)'(TABLE_WORDS);
  localparam logic [QPTR_W:0]    QFull    = (QPTR_W + 1)'(QDEPTH);

  ftw_job_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push;
  ftw_job_t          job;

  // classify the incoming item
  always_comb begin
    job.command       = in_data.command;
    job.wr_ok         = ({1'b0, in_data.table_index} < WordsLim);
    job.table_index   = in_data.table_index;
    job.table_word    = in_data.table_word;
    job.input_address = in_data.input_address;
  end

  assign in_stall = (cnt_r == QFull);
  assign push     = in_valid && !in_stall;

  assign q_out.valid = (cnt_r != '0);
  assign q_out.job   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= job;
    end
  end

endmodule

// ===== rtl/ftw_back.sv =====
// back end: performs table writes and four-level walks, holds the result register
// depends on ftw_pkg; drives the descriptor ram through ftw_mem_req_t
module ftw_back #(
  parameter int unsigned TABLE_WORDS = ftw_pkg::TABLE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ftw_pkg::ftw_q_t               q_in,
  output logic                          pop,
  input  logic [ftw_pkg::ADDR_W-1:0]    root_base,
  output ftw_pkg::ftw_mem_req_t         mem_req,
  input  logic [ftw_pkg::WORD_W-1:0]    mem_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ftw_pkg::ftw_out_t             out_data
);
  import ftw_pkg::*;

  localparam logic [TBL_IDX_W:0] WordsLim = (TBL_IDX_W + 1)'(TABLE_WORDS);

  bk_state_t           state_r, state_nxt;
  logic [1:0]          level_r, level_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]   ia_r, ia_nxt;
  logic                out_valid_r, out_valid_nxt;
  ftw_out_t            out_data_r, out_data_nxt;

  logic                 out_free;
  logic                 start;
  logic [SLICE_W-1:0]   slice;
  logic [ADDR_W-1:0]    da;
  logic [TBL_IDX_W-1:0] da_idx;
  logic                 da_ok;
  logic [ADDR_W-1:0]    pa;
  logic                 pa_ok;
  logic                 desc_valid;

  assign out_free = !out_valid_r || !out_stall;
  assign start    = q_in.valid && out_free;

  // 9-bit table offset for the current level
  always_comb begin
    case (level_r)
      2'd0:    slice = ia_r[47:39];
      2'd1:    slice = ia_r[38:30];
      2'd2:    slice = ia_r[29:21];
      default: slice = ia_r[20:12];
    endcase
  end

  assign da         = {base_r[ADDR_W-1:PAGE_W], slice, 3'b000};
  assign da_idx     = da[22:3];
  assign da_ok      = (da[47:23] == TBL_WIN_TAG) && ({1'b0, da_idx} < WordsLim);
  assign pa         = {mem_rdata[ADDR_W-1:PAGE_W], ia_r[PAGE_W-1:0]};
  assign pa_ok      = (pa[47:28] == MEM_WIN_TAG);
  assign desc_valid = mem_rdata[DESC_VALID_BIT];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start && q_in.job.command == CMD_XLATE) begin
          state_nxt = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        state_nxt = da_ok ? BK_CHECK : BK_IDLE;
      end
      BK_CHECK: begin
        state_nxt = (desc_valid && level_r != LAST_LEVEL) ? BK_LOOKUP : BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = da_idx;
    mem_req.wdata = q_in.job.table_word;
    level_nxt     = level_r;
    base_nxt      = base_r;
    ia_nxt        = ia_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start) begin
          pop = 1'b1;
          if (q_in.job.command == CMD_WRITE) begin
            mem_req.we                  = q_in.job.wr_ok;
            mem_req.addr                = q_in.job.table_index;
            out_valid_nxt               = 1'b1;
            out_data_nxt.output_address = '0;
            out_data_nxt.status         = ST_OK;
          end else begin
            ia_nxt    = q_in.job.input_address;
            base_nxt  = root_base;
            level_nxt = '0;
          end
        end
      end
      BK_LOOKUP: begin
        if (da_ok) begin
          mem_req.re = 1'b1;
        end else begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.output_address = '0;
          out_data_nxt.status         = ST_TABLE_RANGE;
        end
      end
      BK_CHECK: begin
        if (!desc_valid) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.output_address = '0;
          out_data_nxt.status         = ST_UNMAPPED;
        end else if (level_r == LAST_LEVEL) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.output_address = pa_ok ? pa : '0;
          out_data_nxt.status         = pa_ok ? ST_OK : ST_OUT_RANGE;
        end else begin
          base_nxt  = mem_rdata[ADDR_W-1:0];
          level_nxt = level_r + 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r    <= level_nxt;
    base_r     <= base_nxt;
    ia_r       <= ia_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
